>>> hdl/gbss_pkg.sv
// Shared types and constants of the Gaussian blur / Sobel sharpen block.
// Item and result structs, register indexes, kernel weights, reciprocals.
// No dependencies.
`timescale 1ns / 1ps

package gbss_pkg;

  localparam int unsigned COL_W      = 12;
  localparam int unsigned ROW_W      = 13;
  localparam int unsigned DIM_W      = 13;
  localparam int unsigned POS_W      = 15;
  localparam int unsigned PIX_W      = 24;
  localparam int unsigned CFG_IDX_W  = 8;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 8'd1;

  localparam logic [10:0]      WIDTH_RESET  = 11'd640;
  localparam logic [12:0]      HEIGHT_RESET = 13'd480;
  localparam logic [DIM_W-1:0] MIN_DIM      = 13'd3;
  localparam logic [DIM_W-1:0] MAX_HEIGHT   = 13'd4096;

  localparam logic [5:0] GAUSS_W [5][5] = '{
    '{6'd1, 6'd4,  6'd7,  6'd4,  6'd1},
    '{6'd4, 6'd16, 6'd26, 6'd16, 6'd4},
    '{6'd7, 6'd26, 6'd41, 6'd26, 6'd7},
    '{6'd4, 6'd16, 6'd26, 6'd16, 6'd4},
    '{6'd1, 6'd4,  6'd7,  6'd4,  6'd1}
  };

  // floor(x / d) == (x * RECIP) >> SHIFT over each value range in use
  localparam logic [16:0] BLUR_RECIP = 17'd122911;  // d = 273, shift 25
  localparam logic [14:0] GREY_RECIP = 15'd20972;   // d = 100, shift 21
  localparam logic [19:0] EDGE_RECIP = 20'd744104;  // d = 1443, shift 30
  localparam logic [15:0] MAG_SCALE  = 16'd65025;

  typedef struct packed {
    logic       operation;
    logic [7:0] red_in;
    logic [7:0] green_in;
    logic [7:0] blue_in;
  } in_item_t;

  typedef struct packed {
    logic [7:0] red_out;
    logic [7:0] green_out;
    logic [7:0] blue_out;
    logic       frame_end;
  } out_item_t;

  typedef struct packed {
    logic [PIX_W-1:0] sample;
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] row;
  } work_t;

  typedef struct packed {
    logic [DIM_W-1:0] width;
    logic [DIM_W-1:0] height;
  } dims_t;

endpackage

>>> hdl/gbss_fifo.sv
// Two-entry queue with push/full and pop/empty sides.
// Used for the work queue and the result queue; no package use.
`timescale 1ns / 1ps

module gbss_fifo #(
  parameter int unsigned Width = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  output logic             full_o,
  input  logic [Width-1:0] wdata_i,
  input  logic             pop_i,
  output logic             empty_o,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [2];
  logic             wr_ptr_q, rd_ptr_q;
  logic [1:0]       count_q;
  logic             do_push, do_pop;

  assign full_o  = (count_q == 2'd2);
  assign empty_o = (count_q == 2'd0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (do_push) wr_ptr_q <= !wr_ptr_q;
      if (do_pop)  rd_ptr_q <= !rd_ptr_q;
      if (do_push && !do_pop) begin
        count_q <= count_q + 2'd1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_ptr_q] <= wdata_i;
  end

endmodule

>>> hdl/gbss_front.sv
// Front end: accepts items, tracks the stream position, drops drain ticks
// inside a frame and queues work for the back end. Uses gbss_pkg.
`timescale 1ns / 1ps

module gbss_front
  import gbss_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  dims_t    dims_i,
  input  logic     restart_i,
  input  logic     push_i,
  output logic     full_o,
  input  in_item_t item_i,
  output logic     work_push_o,
  input  logic     work_full_i,
  output work_t    work_o
);

  logic [COL_W-1:0] col_q, col_d;
  logic [ROW_W-1:0] row_q, row_d;
  logic             draining, accept, col_wrap, frame_done;

  assign full_o     = work_full_i;
  assign accept     = push_i && !work_full_i;
  assign draining   = ({1'b0, row_q} >= {1'b0, dims_i.height});
  assign work_push_o = accept && (draining || !item_i.operation);
  assign col_wrap   = (({1'b0, col_q} + 13'd1) == dims_i.width);
  assign frame_done = (col_q == 12'd2) &&
                      ({1'b0, row_q} == ({1'b0, dims_i.height} + 14'd3));

  assign work_o.sample = draining ? '0 : {item_i.red_in, item_i.green_in, item_i.blue_in};
  assign work_o.col    = col_q;
  assign work_o.row    = row_q;

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    priority if (restart_i) begin
      col_d = '0;
      row_d = '0;
    end else if (work_push_o) begin
      priority if (frame_done) begin
        col_d = '0;
        row_d = '0;
      end else if (col_wrap) begin
        col_d = '0;
        row_d = row_q + 13'd1;
      end else begin
        col_d = col_q + 12'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

endmodule

>>> hdl/gbss_back.sv
// Back end: line buffers, 5x5 blur, 3x3 grey window, Sobel magnitude with an
// iterative square root, sharpening and result hand-off. Uses gbss_pkg.
`timescale 1ns / 1ps

module gbss_back
  import gbss_pkg::*;
#(
  parameter int unsigned MaxWidth = 1024
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  dims_t     dims_i,
  input  logic      work_valid_i,
  input  work_t     work_i,
  output logic      work_pop_o,
  input  logic      res_full_i,
  output logic      res_push_o,
  output out_item_t res_o
);

  localparam int unsigned CW = $clog2(MaxWidth);

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_SRC   = 4'd1;
  localparam logic [3:0] ST_BLUR  = 4'd2;
  localparam logic [3:0] ST_BDIV  = 4'd3;
  localparam logic [3:0] ST_BWIN  = 4'd4;
  localparam logic [3:0] ST_GREY  = 4'd5;
  localparam logic [3:0] ST_SOBEL = 4'd6;
  localparam logic [3:0] ST_SQX   = 4'd7;
  localparam logic [3:0] ST_SQY   = 4'd8;
  localparam logic [3:0] ST_SCALE = 4'd9;
  localparam logic [3:0] ST_SQRT  = 4'd10;
  localparam logic [3:0] ST_DIV   = 4'd11;
  localparam logic [3:0] ST_OUT   = 4'd12;

  logic [3:0] state_q, state_d;
  logic [2:0] dy_q, dy_d;
  logic [1:0] gk_q, gk_d;
  logic [4:0] it_q, it_d;

  logic [4*PIX_W-1:0] src_mem [MaxWidth];
  logic [2*PIX_W-1:0] blr_mem [MaxWidth];
  logic [4*PIX_W-1:0] src_rd_q, src_wdata;
  logic [2*PIX_W-1:0] blr_rd_q, blr_wdata;

  work_t                   cur_q;
  logic [PIX_W-1:0]        swin_q [5][5];
  logic [PIX_W-1:0]        bwin_q [3][3];
  logic [PIX_W-1:0]        bcol_q [3];
  logic [7:0]              gwin_q [3][3];
  logic [7:0]              gcol_q [2];
  logic signed [POS_W-1:0] bc_q, br_q, oc_q, orow_q;
  logic [16:0]             acc_q [3];
  logic [7:0]              blur_q [3];
  logic signed [11:0]      gx_q, gy_q;
  logic [19:0]             sq_q;
  logic [20:0]             mag_q;
  logic [39:0]             rad_q;
  logic [21:0]             rem_q;
  logic [19:0]             root_q;
  logic [7:0]              add_q;
  logic                    last_q;

  logic signed [POS_W-1:0] w_s, h_s, col_s, row_s, bc_d, br_d, oc_d, orow_d;
  logic [PIX_W-1:0]        strip [5];
  logic [PIX_W-1:0]        bstrip [3];
  logic [16:0]             blur_sum [3];
  logic [7:0]              grey_now;
  logic                    orow_out;
  logic signed [11:0]      gx_d, gy_d;
  logic [23:0]             rem_n, trial;
  logic [8:0]              sat [3];

  assign w_s   = $signed({2'b00, dims_i.width});
  assign h_s   = $signed({2'b00, dims_i.height});
  assign col_s = $signed({3'b000, cur_q.col});
  assign row_s = $signed({2'b00, cur_q.row});
  assign orow_out = (orow_q < 0) || (orow_q >= h_s);

  assign work_pop_o = (state_q == ST_IDLE) && work_valid_i;
  assign res_push_o = (state_q == ST_OUT) && !res_full_i;

  // line buffer strips and write-back words
  always_comb begin
    logic [1:0] slot;
    slot = cur_q.row[1:0];
    for (int dy = 0; dy < 4; dy++) begin
      strip[dy] = src_rd_q[PIX_W * 32'(2'(slot + 2'(dy))) +: PIX_W];
    end
    strip[4]  = cur_q.sample;
    src_wdata = src_rd_q;
    src_wdata[PIX_W * 32'(slot) +: PIX_W] = cur_q.sample;
    bstrip[0] = br_q[0] ? blr_rd_q[PIX_W +: PIX_W] : blr_rd_q[0 +: PIX_W];
    bstrip[1] = br_q[0] ? blr_rd_q[0 +: PIX_W] : blr_rd_q[PIX_W +: PIX_W];
    bstrip[2] = {blur_q[0], blur_q[1], blur_q[2]};
    blr_wdata = blr_rd_q;
    blr_wdata[PIX_W * 32'(br_q[0]) +: PIX_W] = bstrip[2];
  end

  // positions
  always_comb begin
    if (col_s >= 15'sd2) begin
      bc_d = col_s - 15'sd2;
      br_d = row_s - 15'sd2;
    end else begin
      bc_d = col_s + w_s - 15'sd2;
      br_d = row_s - 15'sd3;
    end
    if (bc_q >= 15'sd1) begin
      oc_d   = bc_q - 15'sd1;
      orow_d = br_q - 15'sd1;
    end else begin
      oc_d   = bc_q - 15'sd1 + w_s;
      orow_d = br_q - 15'sd2;
    end
  end

  // one kernel row per cycle
  always_comb begin
    logic signed [POS_W-1:0] r, c;
    logic                    row_ok;
    logic [13:0]             term;
    r = br_q - 15'sd2 + $signed({12'd0, dy_q});
    row_ok = (r >= 0) && (r < h_s);
    for (int ch = 0; ch < 3; ch++) blur_sum[ch] = '0;
    for (int k = 0; k < 5; k++) begin
      c = bc_q - 15'sd2 + 15'(k);
      for (int ch = 0; ch < 3; ch++) begin
        term = GAUSS_W[dy_q][k] * swin_q[dy_q][k][8*(2-ch) +: 8];
        if (row_ok && (c >= 0) && (c < w_s)) begin
          blur_sum[ch] = blur_sum[ch] + 17'(term);
        end
      end
    end
  end

  // grey of one blurred pixel
  always_comb begin
    logic [PIX_W-1:0] px;
    logic [14:0]      x;
    logic [29:0]      p;
    px = bcol_q[gk_q];
    x  = 15'(px[23:16]) * 15'd30 + 15'(px[15:8]) * 15'd59 + 15'(px[7:0]) * 15'd11;
    p  = x * GREY_RECIP;
    grey_now = p[28:21];
  end

  // Sobel over the masked grey window
  always_comb begin
    logic signed [POS_W-1:0] r, c;
    logic signed [11:0]      g [3][3];
    for (int dy = 0; dy < 3; dy++) begin
      r = orow_q - 15'sd1 + 15'(dy);
      for (int k = 0; k < 3; k++) begin
        c = oc_q - 15'sd1 + 15'(k);
        g[dy][k] = ((r >= 0) && (r < h_s) && (c >= 0) && (c < w_s)) ?
                   $signed({4'd0, gwin_q[dy][k]}) : 12'sd0;
      end
    end
    gx_d = (g[0][0] - g[0][2]) + 12'sd2 * (g[1][0] - g[1][2]) + (g[2][0] - g[2][2]);
    gy_d = (g[2][0] - g[0][0]) + 12'sd2 * (g[2][1] - g[0][1]) + (g[2][2] - g[0][2]);
  end

  assign rem_n = {rem_q, rad_q[39:38]};
  assign trial = {2'b00, root_q, 2'b01};

  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      sat[ch] = {1'b0, bwin_q[1][1][8*(2-ch) +: 8]} + {1'b0, add_q};
    end
    res_o.red_out   = sat[0][8] ? 8'hFF : sat[0][7:0];
    res_o.green_out = sat[1][8] ? 8'hFF : sat[1][7:0];
    res_o.blue_out  = sat[2][8] ? 8'hFF : sat[2][7:0];
    res_o.frame_end = last_q;
  end

  always_comb begin
    state_d = state_q;
    dy_d    = dy_q;
    gk_d    = gk_q;
    it_d    = it_q;
    unique case (state_q)
      ST_IDLE:  if (work_valid_i) state_d = ST_SRC;
      ST_SRC: begin
        dy_d    = '0;
        state_d = (br_d < 0) ? ST_IDLE : ST_BLUR;
      end
      ST_BLUR: begin
        dy_d = dy_q + 3'd1;
        if (dy_q == 3'd4) state_d = ST_BDIV;
      end
      ST_BDIV:  state_d = ST_BWIN;
      ST_BWIN: begin
        gk_d    = '0;
        state_d = ST_GREY;
      end
      ST_GREY: begin
        gk_d = gk_q + 2'd1;
        if (gk_q == 2'd2) state_d = orow_out ? ST_IDLE : ST_SOBEL;
      end
      ST_SOBEL: state_d = ST_SQX;
      ST_SQX:   state_d = ST_SQY;
      ST_SQY:   state_d = ST_SCALE;
      ST_SCALE: begin
        it_d    = '0;
        state_d = ST_SQRT;
      end
      ST_SQRT: begin
        it_d = it_q + 5'd1;
        if (it_q == 5'd19) state_d = ST_DIV;
      end
      ST_DIV:   state_d = ST_OUT;
      ST_OUT:   if (!res_full_i) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      dy_q    <= '0;
      gk_q    <= '0;
      it_q    <= '0;
    end else begin
      state_q <= state_d;
      dy_q    <= dy_d;
      gk_q    <= gk_d;
      it_q    <= it_d;
    end
  end

  always_ff @(posedge clk_i) begin
    src_rd_q <= src_mem[work_i.col[CW-1:0]];
    if (state_q == ST_SRC) src_mem[cur_q.col[CW-1:0]] <= src_wdata;
  end

  always_ff @(posedge clk_i) begin
    blr_rd_q <= blr_mem[bc_q[CW-1:0]];
    if (state_q == ST_BWIN) blr_mem[bc_q[CW-1:0]] <= blr_wdata;
  end

  always_ff @(posedge clk_i) begin
    logic [33:0]        bp;
    logic [39:0]        ep;
    logic signed [23:0] sqp;
    unique case (state_q)
      ST_IDLE: cur_q <= work_i;
      ST_SRC: begin
        for (int dy = 0; dy < 5; dy++) begin
          for (int k = 0; k < 4; k++) swin_q[dy][k] <= swin_q[dy][k+1];
          swin_q[dy][4] <= strip[dy];
        end
        bc_q <= bc_d;
        br_q <= br_d;
        for (int ch = 0; ch < 3; ch++) acc_q[ch] <= '0;
      end
      ST_BLUR: begin
        for (int ch = 0; ch < 3; ch++) acc_q[ch] <= acc_q[ch] + blur_sum[ch];
      end
      ST_BDIV: begin
        for (int ch = 0; ch < 3; ch++) begin
          bp = acc_q[ch] * BLUR_RECIP;
          blur_q[ch] <= bp[32:25];
        end
      end
      ST_BWIN: begin
        for (int dy = 0; dy < 3; dy++) begin
          bwin_q[dy][0] <= bwin_q[dy][1];
          bwin_q[dy][1] <= bwin_q[dy][2];
          bwin_q[dy][2] <= bstrip[dy];
          bcol_q[dy]    <= bstrip[dy];
        end
        oc_q   <= oc_d;
        orow_q <= orow_d;
      end
      ST_GREY: begin
        if (gk_q == 2'd2) begin
          for (int dy = 0; dy < 3; dy++) begin
            gwin_q[dy][0] <= gwin_q[dy][1];
            gwin_q[dy][1] <= gwin_q[dy][2];
          end
          gwin_q[0][2] <= gcol_q[0];
          gwin_q[1][2] <= gcol_q[1];
          gwin_q[2][2] <= grey_now;
        end else begin
          gcol_q[gk_q[0]] <= grey_now;
        end
      end
      ST_SOBEL: begin
        gx_q   <= gx_d;
        gy_q   <= gy_d;
        last_q <= (oc_q == w_s - 15'sd1) && (orow_q == h_s - 15'sd1);
      end
      ST_SQX: begin
        sqp  = gx_q * gx_q;
        sq_q <= sqp[19:0];
      end
      ST_SQY: begin
        sqp   = gy_q * gy_q;
        mag_q <= {1'b0, sq_q} + {1'b0, sqp[19:0]};
      end
      ST_SCALE: begin
        rad_q  <= 40'(mag_q) * 40'(MAG_SCALE);
        rem_q  <= '0;
        root_q <= '0;
      end
      ST_SQRT: begin
        rad_q <= {rad_q[37:0], 2'b00};
        if (rem_n >= trial) begin
          rem_q  <= 22'(rem_n - trial);
          root_q <= {root_q[18:0], 1'b1};
        end else begin
          rem_q  <= rem_n[21:0];
          root_q <= {root_q[18:0], 1'b0};
        end
      end
      ST_DIV: begin
        ep    = root_q * EDGE_RECIP;
        add_q <= ep[37:30];
      end
      default: ;
    endcase
  end

endmodule

>>> hdl/gauss_blur_sobel_sharpen.sv
// Back end steps per item: source, blur, blur divide, blur window, grey, Sobel,
// squares, scale, square root, edge divide, out; an item that gives no result leaves
// after the source or grey step. The sequential back end takes one item at a time.
// Results trail inputs by 3*width+3 stream positions; drain items flush them.
// Reset: asynchronous, active low; clears positions and queues, loads 640x480.
// Top level; uses gbss_pkg, gbss_front, gbss_fifo and gbss_back.
`timescale 1ns / 1ps

module gauss_blur_sobel_sharpen
  import gbss_pkg::*;
#(
  parameter int unsigned MAX_WIDTH = 1024
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push,
  output logic                  full,
  input  in_item_t              in_i,
  input  logic                  pop,
  output logic                  empty,
  output out_item_t             out_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  logic [10:0] width_q;
  logic [12:0] height_q;
  dims_t       dims;
  logic        cfg_wr, restart;
  logic        work_push, work_full, work_pop, work_empty;
  work_t       work_in, work_out;
  logic        res_push, res_full;
  out_item_t   res;

  assign cfg_ready_o = 1'b1;
  assign cfg_wr      = cfg_valid_i && cfg_ready_o;
  assign restart     = cfg_wr &&
                       (cfg_index_i == CFG_FRAME_WIDTH || cfg_index_i == CFG_FRAME_HEIGHT);

  always_comb begin
    if ({2'b00, width_q} < MIN_DIM) begin
      dims.width = MIN_DIM;
    end else if ({2'b00, width_q} > DIM_W'(MAX_WIDTH)) begin
      dims.width = DIM_W'(MAX_WIDTH);
    end else begin
      dims.width = {2'b00, width_q};
    end
    if (height_q < MIN_DIM) begin
      dims.height = MIN_DIM;
    end else if (height_q > MAX_HEIGHT) begin
      dims.height = MAX_HEIGHT;
    end else begin
      dims.height = height_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WIDTH_RESET;
      height_q <= HEIGHT_RESET;
    end else if (cfg_wr) begin
      if (cfg_index_i == CFG_FRAME_WIDTH)  width_q  <= cfg_data_i[10:0];
      if (cfg_index_i == CFG_FRAME_HEIGHT) height_q <= cfg_data_i[12:0];
    end
  end

  gbss_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .dims_i      (dims),
    .restart_i   (restart),
    .push_i      (push),
    .full_o      (full),
    .item_i      (in_i),
    .work_push_o (work_push),
    .work_full_i (work_full),
    .work_o      (work_in)
  );

  gbss_fifo #(
    .Width($bits(work_t))
  ) u_work_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (work_push),
    .full_o  (work_full),
    .wdata_i (work_in),
    .pop_i   (work_pop),
    .empty_o (work_empty),
    .rdata_o (work_out)
  );

  gbss_back #(
    .MaxWidth(MAX_WIDTH)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .dims_i       (dims),
    .work_valid_i (!work_empty),
    .work_i       (work_out),
    .work_pop_o   (work_pop),
    .res_full_i   (res_full),
    .res_push_o   (res_push),
    .res_o        (res)
  );

  gbss_fifo #(
    .Width($bits(out_item_t))
  ) u_res_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .full_o  (res_full),
    .wdata_i (res),
    .pop_i   (pop),
    .empty_o (empty),
    .rdata_o (out_o)
  );

endmodule

>>> hdl/gbss_checker.sv
// Port-level checks for gauss_blur_sobel_sharpen, bound to the top level.
// Uses gbss_pkg for the result type.
`timescale 1ns / 1ps

module gbss_checker
  import gbss_pkg::*;
(
  input logic      clk_i,
  input logic      rst_ni,
  input logic      push,
  input logic      full,
  input logic      pop,
  input logic      empty,
  input out_item_t out_o,
  input logic      cfg_valid_i,
  input logic      cfg_ready_o
);

  a_res_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && !pop |=> !empty && $stable(out_o))
    else $error("waiting result changed before its transfer");

  a_cfg_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i |-> cfg_ready_o)
    else $error("configuration write stalled");

  a_reset_empty: assert property (@(posedge clk_i)
    !rst_ni |=> empty)
    else $error("result shown right after reset");

  a_reset_full: assert property (@(posedge clk_i)
    !rst_ni |=> !full)
    else $error("input blocked right after reset");

endmodule

bind gauss_blur_sobel_sharpen gbss_checker u_gbss_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .push        (push),
  .full        (full),
  .pop         (pop),
  .empty       (empty),
  .out_o       (out_o),
  .cfg_valid_i (cfg_valid_i),
  .cfg_ready_o (cfg_ready_o)
);
